// ----- design/sle_pkg.sv -----
// shared constants and codes for the sprite line evaluator
package sle_pkg;

    localparam int MEM_AW = 16;

    // item function codes
    localparam logic [1:0] FUNC_REG_WR  = 2'd0;
    localparam logic [1:0] FUNC_MEM_WR  = 2'd1;
    localparam logic [1:0] FUNC_EVAL    = 2'd2;

    // video chip register indexes
    localparam logic [5:0] REG_X_MSB    = 6'h10;
    localparam logic [5:0] REG_ENABLE   = 6'h15;
    localparam logic [5:0] REG_Y_EXP    = 6'h17;
    localparam logic [5:0] REG_MEM_PTR  = 6'h18;
    localparam logic [5:0] REG_PRIO     = 6'h1b;
    localparam logic [5:0] REG_MC       = 6'h1c;
    localparam logic [5:0] REG_X_EXP    = 6'h1d;
    localparam logic [5:0] REG_MC0      = 6'h25;
    localparam logic [5:0] REG_MC1      = 6'h26;
    localparam logic [5:0] REG_COL0     = 6'h27;
    localparam logic [5:0] REG_COUNT    = 6'd47;

    // geometry
    localparam logic [8:0] X_LAST       = 9'd367;
    localparam logic [8:0] X_EDGE       = 9'd368;
    localparam logic [5:0] WIDTH_NORM   = 6'd24;
    localparam logic [5:0] WIDTH_EXP    = 6'd48;
    localparam logic [5:0] HEIGHT_NORM  = 6'd21;
    localparam logic [5:0] HEIGHT_EXP   = 6'd42;
    localparam logic [15:0] PTR_OFFSET  = 16'h03F8;

endpackage

// ----- design/sle_vram.sv -----
// single-port 64 KiB video memory with registered read data
module sle_vram
    import sle_pkg::*;
(
    input  logic              aclk,
    input  logic              we,
    input  logic              re,
    input  logic [MEM_AW-1:0] addr,
    input  logic [7:0]        wdata,
    output logic [7:0]        rdata
);

    logic [7:0] mem [2**MEM_AW];
    logic [7:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- design/sprite_line_evaluator_top.sv -----
// sprite line evaluator: register file, video memory and fetch sequencer
//
//  channel  direction  handshake            payload
//  s_       in         s_valid / s_ready    func, target_address, write_value,
//                                           sprite_index, raster_line
//  m_       out        m_valid / m_ready    active .. pattern_bits
//  cfg_     in         cfg_we               cfg_wdata (bank bits)
//
// write items leave s_ready high; an evaluate item keeps s_ready low through EVAL,
// PAT0, PAT1, PAT2 and LAST, for the pointer read and three dependent pattern reads
// on the one vram port, or through EVAL and LAST only when the sprite is not active
// after reset a clearing pass writes zero to all 65536 vram bytes, one per cycle,
// with s_ready low; configuration writes are taken throughout
// a result waits in the output register; an evaluate finishing while it is
// still occupied holds in its last step until the result is taken
module sprite_line_evaluator_top
    import sle_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        cfg_we,
    input  logic [1:0]  cfg_wdata,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_func,
    input  logic [15:0] s_target_address,
    input  logic [7:0]  s_write_value,
    input  logic [2:0]  s_sprite_index,
    input  logic [8:0]  s_raster_line,

    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_active,
    output logic [8:0]  m_x_position,
    output logic [5:0]  m_pixels_to_draw,
    output logic [1:0]  m_sprite_kind,
    output logic [3:0]  m_colour_one,
    output logic [3:0]  m_colour_two,
    output logic [3:0]  m_colour_three,
    output logic        m_in_front,
    output logic [23:0] m_pattern_bits
);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_EVAL  = 3'd2;
    localparam logic [2:0] S_PAT0  = 3'd3;
    localparam logic [2:0] S_PAT1  = 3'd4;
    localparam logic [2:0] S_PAT2  = 3'd5;
    localparam logic [2:0] S_LAST  = 3'd6;

    logic [2:0]        state_reg, state_next;
    logic [MEM_AW-1:0] clr_cnt_reg;
    logic [1:0]        bank_bits_reg;

    // register file
    logic [7:0] x_regs   [8];
    logic [7:0] y_regs   [8];
    logic [3:0] col_regs [8];
    logic [7:0] xmsb_reg, enable_reg, yexp_reg, prio_reg, mc_reg, xexp_reg;
    logic [3:0] memptr_reg, mc0_reg, mc1_reg;

    // item being evaluated
    logic [2:0]  n_reg;
    logic [8:0]  line_reg;
    logic        act_reg;
    logic [8:0]  x_reg;
    logic [5:0]  width_reg;
    logic [1:0]  kind_reg;
    logic [3:0]  c1_reg, c2_reg, c3_reg;
    logic        front_reg;
    logic [6:0]  sline3_reg;
    logic [MEM_AW-1:0] addr_reg;
    logic [7:0]  b0_reg, b1_reg;

    // output register
    logic        m_valid_reg;
    logic        o_act_reg, o_front_reg;
    logic [8:0]  o_x_reg;
    logic [5:0]  o_width_reg;
    logic [1:0]  o_kind_reg;
    logic [3:0]  o_c1_reg, o_c2_reg, o_c3_reg;
    logic [23:0] o_pat_reg;

    logic        s_xfer;
    logic        out_free;
    logic [1:0]  bank;
    logic [5:0]  reg_idx;
    logic [5:0]  col_idx;
    logic        reg_hit;

    // evaluation logic
    logic [7:0]  e_y;
    logic        e_yexp, e_xexp, e_mc, e_in_y, e_on, e_act;
    logic [9:0]  e_yend;
    logic [8:0]  e_x;
    logic [9:0]  e_xend;
    logic [5:0]  e_wbase, e_width;
    logic [8:0]  e_width9;
    logic [8:0]  e_sdiff;
    logic [5:0]  e_sline;
    logic [6:0]  e_sline3;

    // shared address adder
    logic [MEM_AW-1:0] add_a, add_b, add_sum;

    logic              mem_we, mem_re;
    logic [MEM_AW-1:0] mem_addr;
    logic [7:0]        mem_wdata, mem_rdata;

    assign s_ready  = (state_reg == S_IDLE);
    assign s_xfer   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign bank     = ~bank_bits_reg;
    assign reg_idx  = s_target_address[5:0];
    assign col_idx  = reg_idx - REG_COL0;
    assign reg_hit  = (s_target_address[15:6] == 10'd0) && (reg_idx < REG_COUNT);

    always_comb begin
        e_y      = y_regs[n_reg];
        e_yexp   = yexp_reg[n_reg];
        e_xexp   = xexp_reg[n_reg];
        e_mc     = mc_reg[n_reg];
        e_yend   = {2'b00, e_y} + {4'd0, (e_yexp ? HEIGHT_EXP : HEIGHT_NORM)};
        e_in_y   = ({1'b0, line_reg} >= {2'b00, e_y}) && ({1'b0, line_reg} < e_yend);
        e_x      = {xmsb_reg[n_reg], x_regs[n_reg]};
        e_on     = (e_x <= X_LAST);
        e_act    = enable_reg[n_reg] && e_in_y && e_on;
        e_wbase  = e_xexp ? WIDTH_EXP : WIDTH_NORM;
        e_xend   = {1'b0, e_x} + {4'd0, e_wbase};
        e_width9 = X_EDGE - e_x;
        e_width  = (e_xend > {1'b0, X_LAST}) ? e_width9[5:0] : e_wbase;
        e_sdiff  = line_reg - {1'b0, e_y};
        e_sline  = e_yexp ? e_sdiff[6:1] : e_sdiff[5:0];
        e_sline3 = {e_sline, 1'b0} + {1'b0, e_sline};
    end

    always_comb begin
        add_a = addr_reg;
        add_b = '0;
        unique case (state_reg)
            S_EVAL: begin
                add_a = {bank, memptr_reg, 10'd0};
                add_b = PTR_OFFSET | {13'd0, n_reg};
            end
            S_PAT0: begin
                add_a = {bank, mem_rdata, 6'd0};
                add_b = {9'd0, sline3_reg};
            end
            S_PAT1, S_PAT2: begin
                add_a = addr_reg;
                add_b = 16'd1;
            end
            default: begin
                add_a = addr_reg;
                add_b = '0;
            end
        endcase
        add_sum = add_a + add_b;
    end

    always_comb begin
        mem_we    = 1'b0;
        mem_re    = 1'b0;
        mem_addr  = add_sum;
        mem_wdata = s_write_value;
        priority case (state_reg)
            S_CLEAR: begin
                mem_we    = 1'b1;
                mem_addr  = clr_cnt_reg;
                mem_wdata = 8'd0;
            end
            S_IDLE: begin
                mem_we   = s_xfer && (s_func == FUNC_MEM_WR);
                mem_addr = s_target_address;
            end
            S_EVAL, S_PAT0, S_PAT1, S_PAT2: begin
                mem_re = 1'b1;
            end
            default: begin
                mem_re = 1'b0;
            end
        endcase
    end

    sle_vram u_vram (
        .aclk  (aclk),
        .we    (mem_we),
        .re    (mem_re),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR: if (clr_cnt_reg == '1) begin
                state_next = S_IDLE;
            end
            S_IDLE: if (s_xfer && (s_func == FUNC_EVAL)) begin
                state_next = S_EVAL;
            end
            S_EVAL:  state_next = e_act ? S_PAT0 : S_LAST;
            S_PAT0:  state_next = S_PAT1;
            S_PAT1:  state_next = S_PAT2;
            S_PAT2:  state_next = S_LAST;
            S_LAST: if (out_free) begin
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_CLEAR;
            clr_cnt_reg   <= '0;
            bank_bits_reg <= 2'd0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == S_CLEAR) begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            if (cfg_we) begin
                bank_bits_reg <= cfg_wdata;
            end
            if (state_reg == S_LAST && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // register file, cleared by reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 8; i++) begin
                x_regs[i]   <= 8'd0;
                y_regs[i]   <= 8'd0;
                col_regs[i] <= 4'd0;
            end
            xmsb_reg   <= 8'd0;
            enable_reg <= 8'd0;
            yexp_reg   <= 8'd0;
            prio_reg   <= 8'd0;
            mc_reg     <= 8'd0;
            xexp_reg   <= 8'd0;
            memptr_reg <= 4'd0;
            mc0_reg    <= 4'd0;
            mc1_reg    <= 4'd0;
        end else if (s_xfer && (s_func == FUNC_REG_WR) && reg_hit) begin
            priority if (reg_idx[5:4] == 2'd0) begin
                if (reg_idx[0]) begin
                    y_regs[reg_idx[3:1]] <= s_write_value;
                end else begin
                    x_regs[reg_idx[3:1]] <= s_write_value;
                end
            end else if (reg_idx >= REG_COL0) begin
                col_regs[col_idx[2:0]] <= s_write_value[3:0];
            end else if (reg_idx == REG_X_MSB) begin
                xmsb_reg <= s_write_value;
            end else if (reg_idx == REG_ENABLE) begin
                enable_reg <= s_write_value;
            end else if (reg_idx == REG_Y_EXP) begin
                yexp_reg <= s_write_value;
            end else if (reg_idx == REG_MEM_PTR) begin
                memptr_reg <= s_write_value[7:4];
            end else if (reg_idx == REG_PRIO) begin
                prio_reg <= s_write_value;
            end else if (reg_idx == REG_MC) begin
                mc_reg <= s_write_value;
            end else if (reg_idx == REG_X_EXP) begin
                xexp_reg <= s_write_value;
            end else if (reg_idx == REG_MC0) begin
                mc0_reg <= s_write_value[3:0];
            end else if (reg_idx == REG_MC1) begin
                mc1_reg <= s_write_value[3:0];
            end
        end
    end

    // evaluation datapath
    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            n_reg    <= s_sprite_index;
            line_reg <= s_raster_line;
        end
        if (state_reg == S_EVAL) begin
            act_reg    <= e_act;
            x_reg      <= e_act ? e_x : 9'd0;
            width_reg  <= e_act ? e_width : 6'd0;
            kind_reg   <= e_act ? {e_xexp, e_mc} : 2'd0;
            c1_reg     <= !e_act ? 4'd0 : (e_mc ? mc0_reg : col_regs[n_reg]);
            c2_reg     <= (e_act && e_mc) ? col_regs[n_reg] : 4'd0;
            c3_reg     <= (e_act && e_mc) ? mc1_reg : 4'd0;
            front_reg  <= e_act && !prio_reg[n_reg];
            sline3_reg <= e_sline3;
        end
        if (state_reg == S_PAT0 || state_reg == S_PAT1 || state_reg == S_PAT2) begin
            addr_reg <= add_sum;
        end
        if (state_reg == S_PAT1) begin
            b0_reg <= mem_rdata;
        end
        if (state_reg == S_PAT2) begin
            b1_reg <= mem_rdata;
        end
        if (state_reg == S_LAST && out_free) begin
            o_act_reg   <= act_reg;
            o_x_reg     <= x_reg;
            o_width_reg <= width_reg;
            o_kind_reg  <= kind_reg;
            o_c1_reg    <= c1_reg;
            o_c2_reg    <= c2_reg;
            o_c3_reg    <= c3_reg;
            o_front_reg <= front_reg;
            o_pat_reg   <= act_reg ? {b0_reg, b1_reg, mem_rdata} : 24'd0;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_active         = o_act_reg;
    assign m_x_position     = o_x_reg;
    assign m_pixels_to_draw = o_width_reg;
    assign m_sprite_kind    = o_kind_reg;
    assign m_colour_one     = o_c1_reg;
    assign m_colour_two     = o_c2_reg;
    assign m_colour_three   = o_c3_reg;
    assign m_in_front       = o_front_reg;
    assign m_pattern_bits   = o_pat_reg;

endmodule

// ----- design/sle_checker.sv -----
// port-level checks for the sprite line evaluator, bound to the top level
module sle_checker
    import sle_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        m_valid,
    input logic        m_ready,
    input logic        m_active,
    input logic [8:0]  m_x_position,
    input logic [5:0]  m_pixels_to_draw,
    input logic [1:0]  m_sprite_kind,
    input logic [3:0]  m_colour_two,
    input logic [3:0]  m_colour_three,
    input logic        m_in_front,
    input logic [23:0] m_pattern_bits
);

    // no result leaves right after reset
    a_reset_quiet: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_pattern_bits)
            && $stable(m_x_position) && $stable(m_pixels_to_draw))
        else $error("stalled result changed");

    // an inactive sprite reports zero position, width, kind, front flag and pattern
    a_inactive_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_active |-> m_x_position == 9'd0 && m_pixels_to_draw == 6'd0
            && m_sprite_kind == 2'd0 && !m_in_front && m_pattern_bits == 24'd0)
        else $error("inactive sprite with nonzero fields");

    // an active sprite has a nonzero width and stays inside the visible edge
    a_clip: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_active |-> m_pixels_to_draw != 6'd0
            && ({1'b0, m_x_position} + {4'd0, m_pixels_to_draw}) <= {1'b0, X_EDGE})
        else $error("sprite width not clipped");

    // single colour sprites leave the extra colours empty
    a_single_colour: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_sprite_kind[0] |-> m_colour_two == 4'd0 && m_colour_three == 4'd0)
        else $error("single colour sprite with extra colours");

endmodule

bind sprite_line_evaluator_top sle_checker u_sle_checker (
    .aclk             (aclk),
    .aresetn          (aresetn),
    .m_valid          (m_valid),
    .m_ready          (m_ready),
    .m_active         (m_active),
    .m_x_position     (m_x_position),
    .m_pixels_to_draw (m_pixels_to_draw),
    .m_sprite_kind    (m_sprite_kind),
    .m_colour_two     (m_colour_two),
    .m_colour_three   (m_colour_three),
    .m_in_front       (m_in_front),
    .m_pattern_bits   (m_pattern_bits)
);
